// ===== sv/wdh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wdh_pkg: shared types and constants of the waveform density histogram
// Payload structs, status and opcode codes, channel id table and helpers.
// ----------------------------------------------------------------------------
package wdh_pkg;

    localparam int COUNT_W         = 32;
    localparam int LENGTH_W        = 9;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 2;
    localparam int ID_W            = 12;
    localparam int ADC_W           = 16;
    localparam int ADC_MAG_W       = ADC_W - 1;
    localparam int ADC_SCALE_SHIFT = 14;   // full scale of 16384
    localparam int RD_SAMPLE_W     = 8;
    localparam int RD_BIN_W        = 7;
    localparam int ID_TABLE_SIZE   = 32;
    localparam int CHAN_IDX_W      = $clog2(ID_TABLE_SIZE);

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 9'd256;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    localparam logic [ID_W-1:0] CHANNEL_IDS [ID_TABLE_SIZE] = '{
        12'd1010, 12'd1011, 12'd1020, 12'd1021, 12'd1030, 12'd1031, 12'd1040, 12'd1041,
        12'd1050, 12'd1051, 12'd1060, 12'd1061, 12'd1070, 12'd1071, 12'd1080, 12'd1081,
        12'd2010, 12'd2011, 12'd2020, 12'd2021, 12'd2030, 12'd2031, 12'd2040, 12'd2041,
        12'd2050, 12'd2051, 12'd2060, 12'd2061, 12'd2070, 12'd2071, 12'd2080, 12'd2081
    };

    typedef enum logic [0:0] {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ACCUMULATED  = 3'd0,
        ST_IGNORED      = 3'd1,
        ST_LEN_ERROR    = 3'd2,
        ST_READ_OK      = 3'd3,
        ST_READ_UNKNOWN = 3'd4
    } status_t;

    localparam logic [APB_ADDR_W-1:0] REG_WAVEFORM_LENGTH = 2'd0;

    typedef struct packed {
        opcode_t                  opcode;
        logic [ID_W-1:0]          channel_id;
        logic signed [ADC_W-1:0]  adc_value;
        logic                     last_sample;
        logic [RD_SAMPLE_W-1:0]   read_sample_index;
        logic [RD_BIN_W-1:0]      read_amplitude_bin;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  bin_count;
        logic [COUNT_W-1:0]  waveform_count;
    } out_item_t;

    // Control of one decoded item on its way to the memories
    typedef struct packed {
        logic    valid;
        logic    known;
        status_t status;
        logic    dens_rd;
        logic    dens_inc;
        logic    wf_inc;
    } dec_ctrl_t;

    typedef struct packed {
        logic                  found;
        logic [CHAN_IDX_W-1:0] index;
    } chan_hit_t;

    function automatic chan_hit_t chan_lookup(input logic [ID_W-1:0] id, input int num);
        chan_hit_t hit;
        hit = '0;
        for (int i = 0; i < ID_TABLE_SIZE; i++) begin
            if (i < num && CHANNEL_IDS[i] == id) begin
                hit.found = 1'b1;
                hit.index = CHAN_IDX_W'(i);
            end
        end
        return hit;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== sv/waveform_density_histogram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_density_histogram: per-channel waveform density histogram
// Counts samples per (channel, sample position, amplitude bin) and complete
// waveforms per channel; read transfers return one bin and the waveform count.
// ----------------------------------------------------------------------------
//  channel  | ports                          | payload       | role
//  ---------+--------------------------------+---------------+------------------
//  input    | s_valid, s_ready, s_item       | in_item_t     | samples and reads
//  result   | m_valid, m_ready, m_item       | out_item_t    | one per input
//  config   | psel, penable, pwrite, paddr.. | 32-bit APB    | waveform_length
//
//  One transfer per cycle unless clearing or stalled. A result moves from the
//  input and decode registers through the density read-modify-write (address
//  and memory stages, registered read, one-entry write-back forwarding) to the
//  output register. After reset a clearing pass over all NUM_CHANNELS *
//  MAX_SAMPLES * AMPLITUDE_BINS entries zeroes the counters; s_ready stays low
//  meanwhile. m_ready low freezes all stages while the result register is full.
// ----------------------------------------------------------------------------
module waveform_density_histogram #(
    parameter int NUM_CHANNELS   = 32,
    parameter int MAX_SAMPLES    = 256,
    parameter int AMPLITUDE_BINS = 100
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  wdh_pkg::in_item_t                  s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output wdh_pkg::out_item_t                 m_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wdh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wdh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wdh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    import wdh_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SMP_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int BIN_W = $clog2(AMPLITUDE_BINS);

    logic [LENGTH_W-1:0] length_reg;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    logic                advance;
    logic                s_accept;
    logic                clearing;
    dec_ctrl_t           dec_ctrl;
    logic [CH_W-1:0]     dec_ch;
    logic [SMP_W-1:0]    dec_sample;
    logic [BIN_W-1:0]    dec_bin;
    logic                res_valid;
    out_item_t           res_item;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= LENGTH_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr)
                REG_WAVEFORM_LENGTH: length_reg <= pwdata[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_WAVEFORM_LENGTH: prdata = APB_DATA_W'(length_reg);
            default:             prdata = '0;
        endcase
    end

    // The pipeline moves as one while the result register can take a transfer
    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = advance && !clearing;
    assign s_accept = s_valid && s_ready;

    wdh_decode #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .MAX_SAMPLES   (MAX_SAMPLES),
        .AMPLITUDE_BINS(AMPLITUDE_BINS),
        .CH_W          (CH_W),
        .SMP_W         (SMP_W),
        .BIN_W         (BIN_W)
    ) u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .s_accept       (s_accept),
        .s_item         (s_item),
        .waveform_length(length_reg),
        .dec_ctrl       (dec_ctrl),
        .dec_ch         (dec_ch),
        .dec_sample     (dec_sample),
        .dec_bin        (dec_bin)
    );

    wdh_update #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .MAX_SAMPLES   (MAX_SAMPLES),
        .AMPLITUDE_BINS(AMPLITUDE_BINS),
        .CH_W          (CH_W),
        .SMP_W         (SMP_W),
        .BIN_W         (BIN_W)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .dec_ctrl  (dec_ctrl),
        .dec_ch    (dec_ch),
        .dec_sample(dec_sample),
        .dec_bin   (dec_bin),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // Result register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end
        if (advance) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

// ===== sv/wdh_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wdh_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered, old data on a
// read of the entry being written.
// ----------------------------------------------------------------------------
module wdh_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/wdh_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wdh_decode: input register, channel match, amplitude binning and sequencing
// Tracks the shared sample position and the drop state, and classifies each
// transfer before it reaches the counter memories.
// ----------------------------------------------------------------------------
module wdh_decode #(
    parameter int NUM_CHANNELS   = 32,
    parameter int MAX_SAMPLES    = 256,
    parameter int AMPLITUDE_BINS = 100,
    parameter int CH_W           = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    parameter int SMP_W          = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int BIN_W          = $clog2(AMPLITUDE_BINS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      s_accept,
    input  wdh_pkg::in_item_t         s_item,
    input  logic [wdh_pkg::LENGTH_W-1:0] waveform_length,
    output wdh_pkg::dec_ctrl_t        dec_ctrl,
    output logic [CH_W-1:0]           dec_ch,
    output logic [SMP_W-1:0]          dec_sample,
    output logic [BIN_W-1:0]          dec_bin
);

    import wdh_pkg::*;

    localparam int POS_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (POS_W > LENGTH_W) ? POS_W : LENGTH_W;
    localparam int PROD_W = ADC_MAG_W + BIN_W + 1;
    localparam int SCL_W  = PROD_W - ADC_SCALE_SHIFT;

    logic              in_valid_reg;
    in_item_t          in_item_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              drop_reg, drop_next;

    dec_ctrl_t         dec_ctrl_reg, dec_ctrl_next;
    logic [CH_W-1:0]   dec_ch_reg, dec_ch_next;
    logic [SMP_W-1:0]  dec_sample_reg, dec_sample_next;
    logic [BIN_W-1:0]  dec_bin_reg, dec_bin_next;

    chan_hit_t         hit;
    logic [CH_W-1:0]   ch_idx;
    logic [CMP_W-1:0]  eff_len;
    logic [CMP_W-1:0]  pos_ext;
    logic              len_bad;
    logic              adc_pos;
    logic [PROD_W-1:0] prod;
    logic [SCL_W-1:0]  scaled;
    logic [BIN_W-1:0]  amp_bin;
    logic              rd_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_accept;
        end
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    assign hit    = chan_lookup(in_item_reg.channel_id, NUM_CHANNELS);
    assign ch_idx = CH_W'(hit.index);

    // A length of zero acts as one, anything past the store depth as the depth
    always_comb begin
        if (waveform_length == '0) begin
            eff_len = CMP_W'(1);
        end else if (CMP_W'(waveform_length) > CMP_W'(MAX_SAMPLES)) begin
            eff_len = CMP_W'(MAX_SAMPLES);
        end else begin
            eff_len = CMP_W'(waveform_length);
        end
    end

    assign pos_ext = CMP_W'(pos_reg);
    assign len_bad = (pos_ext >= eff_len) ||
                     (in_item_reg.last_sample && (pos_ext + CMP_W'(1) != eff_len));

    // floor(adc * bins / 16384) clamped to the top bin, negatives and zero in the bottom bin
    assign adc_pos = !in_item_reg.adc_value[ADC_W-1] &&
                     (in_item_reg.adc_value[ADC_MAG_W-1:0] != '0);
    assign prod    = PROD_W'(in_item_reg.adc_value[ADC_MAG_W-1:0]) *
                     PROD_W'(AMPLITUDE_BINS);
    assign scaled  = prod[PROD_W-1:ADC_SCALE_SHIFT];

    always_comb begin
        if (!adc_pos) begin
            amp_bin = '0;
        end else if (scaled > SCL_W'(AMPLITUDE_BINS - 1)) begin
            amp_bin = BIN_W'(AMPLITUDE_BINS - 1);
        end else begin
            amp_bin = BIN_W'(scaled);
        end
    end

    assign rd_in_range = (32'(in_item_reg.read_sample_index) < 32'(MAX_SAMPLES)) &&
                         (32'(in_item_reg.read_amplitude_bin) < 32'(AMPLITUDE_BINS));

    always_comb begin
        dec_ctrl_next        = '0;
        dec_ctrl_next.valid  = in_valid_reg;
        dec_ctrl_next.status = ST_IGNORED;
        dec_ch_next          = ch_idx;
        dec_sample_next      = '0;
        dec_bin_next         = '0;
        pos_next             = pos_reg;
        drop_next            = drop_reg;

        if (in_item_reg.opcode == OP_READ) begin
            if (!hit.found) begin
                dec_ctrl_next.status = ST_READ_UNKNOWN;
            end else begin
                dec_ctrl_next.status  = ST_READ_OK;
                dec_ctrl_next.known   = 1'b1;
                dec_ctrl_next.dens_rd = rd_in_range;
                if (rd_in_range) begin
                    dec_sample_next = SMP_W'(in_item_reg.read_sample_index);
                    dec_bin_next    = BIN_W'(in_item_reg.read_amplitude_bin);
                end
            end
        end else if (hit.found) begin
            dec_ctrl_next.known = 1'b1;
            if (drop_reg) begin
                // drop the rest of a broken waveform up to its last sample
                dec_ctrl_next.status = ST_LEN_ERROR;
                pos_next             = '0;
                if (in_item_reg.last_sample) begin
                    drop_next = 1'b0;
                end
            end else if (len_bad) begin
                dec_ctrl_next.status = ST_LEN_ERROR;
                pos_next             = '0;
                drop_next            = !in_item_reg.last_sample;
            end else begin
                dec_ctrl_next.status   = ST_ACCUMULATED;
                dec_ctrl_next.dens_inc = 1'b1;
                dec_sample_next        = SMP_W'(pos_reg);
                dec_bin_next           = amp_bin;
                if (in_item_reg.last_sample) begin
                    dec_ctrl_next.wf_inc = 1'b1;
                    pos_next             = '0;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            drop_reg     <= 1'b0;
            dec_ctrl_reg <= '0;
        end else if (advance) begin
            dec_ctrl_reg <= dec_ctrl_next;
            if (in_valid_reg) begin
                pos_reg  <= pos_next;
                drop_reg <= drop_next;
            end
        end
        if (advance) begin
            dec_ch_reg     <= dec_ch_next;
            dec_sample_reg <= dec_sample_next;
            dec_bin_reg    <= dec_bin_next;
        end
    end

    assign dec_ctrl   = dec_ctrl_reg;
    assign dec_ch     = dec_ch_reg;
    assign dec_sample = dec_sample_reg;
    assign dec_bin    = dec_bin_reg;

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) <= 32'(MAX_SAMPLES))
        else $error("sample position beyond store depth");

    a_drop_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |-> (pos_reg == '0))
        else $error("sample position moved while dropping");

    a_wf_ends_waveform: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_ctrl_reg.valid && dec_ctrl_reg.wf_inc) |-> (pos_reg == '0 && !drop_reg))
        else $error("completed waveform left sequencing state behind");
`endif

endmodule
`default_nettype wire

// ===== sv/wdh_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wdh_update: counter memories, read-modify-write and clearing pass
// Forms the bin address, reads both counters, forwards the previous write on
// an address match, writes the saturated increment back and builds results.
// ----------------------------------------------------------------------------
module wdh_update #(
    parameter int NUM_CHANNELS   = 32,
    parameter int MAX_SAMPLES    = 256,
    parameter int AMPLITUDE_BINS = 100,
    parameter int CH_W           = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    parameter int SMP_W          = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int BIN_W          = $clog2(AMPLITUDE_BINS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  wdh_pkg::dec_ctrl_t  dec_ctrl,
    input  logic [CH_W-1:0]     dec_ch,
    input  logic [SMP_W-1:0]    dec_sample,
    input  logic [BIN_W-1:0]    dec_bin,
    output logic                clearing,
    output logic                res_valid,
    output wdh_pkg::out_item_t  res_item
);

    import wdh_pkg::*;

    localparam int DENS_DEPTH = NUM_CHANNELS * MAX_SAMPLES * AMPLITUDE_BINS;
    localparam int ROW_SIZE   = MAX_SAMPLES * AMPLITUDE_BINS;
    localparam int DA_W       = $clog2(DENS_DEPTH);

    dec_ctrl_t           adr_ctrl_reg;
    logic [CH_W-1:0]     adr_ch_reg;
    logic [SMP_W-1:0]    adr_sample_reg;
    logic [BIN_W-1:0]    adr_bin_reg;
    logic [DA_W-1:0]     adr_addr;

    dec_ctrl_t           mem_ctrl_reg;
    logic [CH_W-1:0]     mem_ch_reg;
    logic [DA_W-1:0]     mem_addr_reg;

    logic                clearing_reg;
    logic [DA_W-1:0]     clr_cnt_reg;

    logic                fwd_dens_valid_reg;
    logic [DA_W-1:0]     fwd_dens_addr_reg;
    logic [COUNT_W-1:0]  fwd_dens_data_reg;
    logic                fwd_wf_valid_reg;
    logic [CH_W-1:0]     fwd_wf_ch_reg;
    logic [COUNT_W-1:0]  fwd_wf_data_reg;

    logic [COUNT_W-1:0]  dens_q, wf_q;
    logic [COUNT_W-1:0]  cur_dens, cur_wf;
    logic [COUNT_W-1:0]  dens_new, wf_new;
    logic                dens_upd, wf_upd;

    logic                dens_we, wf_we;
    logic [DA_W-1:0]     dens_waddr;
    logic [CH_W-1:0]     wf_waddr;
    logic [COUNT_W-1:0]  dens_wdata, wf_wdata;

    // Address and memory stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adr_ctrl_reg <= '0;
            mem_ctrl_reg <= '0;
        end else if (advance) begin
            adr_ctrl_reg <= dec_ctrl;
            mem_ctrl_reg <= adr_ctrl_reg;
        end
        if (advance) begin
            adr_ch_reg     <= dec_ch;
            adr_sample_reg <= dec_sample;
            adr_bin_reg    <= dec_bin;
            mem_ch_reg     <= adr_ch_reg;
            mem_addr_reg   <= adr_addr;
        end
    end

    assign adr_addr = DA_W'(adr_ch_reg) * DA_W'(ROW_SIZE) +
                      DA_W'(adr_sample_reg) * DA_W'(AMPLITUDE_BINS) +
                      DA_W'(adr_bin_reg);

    // Clearing pass: one density entry per cycle, totals over the first entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_cnt_reg == DA_W'(DENS_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + DA_W'(1);
            end
        end
    end

    // Memory stage: take the previous write over stale read data
    assign cur_dens = (fwd_dens_valid_reg && fwd_dens_addr_reg == mem_addr_reg) ?
                      fwd_dens_data_reg : dens_q;
    assign cur_wf   = (fwd_wf_valid_reg && fwd_wf_ch_reg == mem_ch_reg) ?
                      fwd_wf_data_reg : wf_q;
    assign dens_new = sat_inc(cur_dens);
    assign wf_new   = sat_inc(cur_wf);

    assign dens_upd = advance && mem_ctrl_reg.valid && mem_ctrl_reg.dens_inc;
    assign wf_upd   = advance && mem_ctrl_reg.valid && mem_ctrl_reg.wf_inc;

    always_comb begin
        if (clearing_reg) begin
            dens_we    = 1'b1;
            dens_waddr = clr_cnt_reg;
            dens_wdata = '0;
            wf_we      = 32'(clr_cnt_reg) < 32'(NUM_CHANNELS);
            wf_waddr   = clr_cnt_reg[CH_W-1:0];
            wf_wdata   = '0;
        end else begin
            dens_we    = dens_upd;
            dens_waddr = mem_addr_reg;
            dens_wdata = dens_new;
            wf_we      = wf_upd;
            wf_waddr   = mem_ch_reg;
            wf_wdata   = wf_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_dens_valid_reg <= 1'b0;
            fwd_wf_valid_reg   <= 1'b0;
        end else if (advance) begin
            fwd_dens_valid_reg <= dens_upd;
            fwd_wf_valid_reg   <= wf_upd;
        end
        if (advance) begin
            fwd_dens_addr_reg <= mem_addr_reg;
            fwd_dens_data_reg <= dens_new;
            fwd_wf_ch_reg     <= mem_ch_reg;
            fwd_wf_data_reg   <= wf_new;
        end
    end

    wdh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DENS_DEPTH),
        .ADDR_W(DA_W)
    ) u_dens_ram (
        .aclk   (aclk),
        .wr_en  (dens_we),
        .wr_addr(dens_waddr),
        .wr_data(dens_wdata),
        .rd_en  (advance),
        .rd_addr(adr_addr),
        .rd_data(dens_q)
    );

    wdh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_CHANNELS),
        .ADDR_W(CH_W)
    ) u_wf_ram (
        .aclk   (aclk),
        .wr_en  (wf_we),
        .wr_addr(wf_waddr),
        .wr_data(wf_wdata),
        .rd_en  (advance),
        .rd_addr(adr_ch_reg),
        .rd_data(wf_q)
    );

    always_comb begin
        res_item.status         = mem_ctrl_reg.status;
        res_item.bin_count      = mem_ctrl_reg.dens_rd ? cur_dens : '0;
        res_item.waveform_count = '0;
        if (mem_ctrl_reg.known) begin
            res_item.waveform_count = mem_ctrl_reg.wf_inc ? wf_new : cur_wf;
        end
    end

    assign res_valid = mem_ctrl_reg.valid;
    assign clearing  = clearing_reg;

`ifndef SYNTHESIS
    a_no_items_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> (!adr_ctrl_reg.valid && !mem_ctrl_reg.valid))
        else $error("item in flight during clearing pass");

    a_inc_only_accumulated: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctrl_reg.valid && mem_ctrl_reg.dens_inc) |->
            (mem_ctrl_reg.status == ST_ACCUMULATED && !mem_ctrl_reg.dens_rd))
        else $error("bin increment on an item that was not accumulated");

    a_wf_needs_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctrl_reg.valid && mem_ctrl_reg.wf_inc) |-> mem_ctrl_reg.dens_inc)
        else $error("waveform counted without its last sample");

    a_fwd_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (dens_upd && !clearing_reg) |=> fwd_dens_valid_reg)
        else $error("density write not forwarded");
`endif

endmodule
`default_nettype wire
